FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/iphs_pkg.sv
// ----------------------------------------------------------------------------
// iphs_pkg
// types and constants of the peak-and-hold injector sequencer
// ----------------------------------------------------------------------------
package iphs_pkg;

  localparam int PULSE_W  = 16;
  localparam int PERIOD_W = 16;
  localparam int TICKS_W  = 10;
  localparam int DUTY_W   = 7;
  localparam int ELAP_W   = 18;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // duty * period, 7 x 16 bits
  localparam int PROD_W = DUTY_W + PERIOD_W;

  // x / 100 == ((x >> 2) * DIV25_MUL) >> DIV25_SHIFT, exact for x < 2**23
  localparam int                DIV25_SHIFT = 26;
  localparam int                DIV25_MUL_W = 22;
  localparam logic [21:0]       DIV25_MUL   = 22'd2684355;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PEAK   = 3'd1,
    PH_SECOND = 3'd2,
    PH_HOLD   = 3'd3,
    PH_OFF    = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_TICKS   = 4'd0,
    REG_SECOND_TICKS = 4'd1,
    REG_OFF_TICKS    = 4'd2,
    REG_FAST_PERIOD  = 4'd3,
    REG_HOLD_PERIOD  = 4'd4,
    REG_PEAK_DUTY    = 4'd5,
    REG_SECOND_DUTY  = 4'd6,
    REG_HOLD_DUTY    = 4'd7
  } reg_idx_t;

  localparam logic [TICKS_W-1:0]  RST_PEAK_TICKS   = 10'd57;
  localparam logic [TICKS_W-1:0]  RST_SECOND_TICKS = 10'd55;
  localparam logic [TICKS_W-1:0]  RST_OFF_TICKS    = 10'd20;
  localparam logic [PERIOD_W-1:0] RST_FAST_PERIOD  = 16'd800;
  localparam logic [PERIOD_W-1:0] RST_HOLD_PERIOD  = 16'd2000;
  localparam logic [DUTY_W-1:0]   RST_PEAK_DUTY    = 7'd32;
  localparam logic [DUTY_W-1:0]   RST_SECOND_DUTY  = 7'd83;
  localparam logic [DUTY_W-1:0]   RST_HOLD_DUTY    = 7'd90;

endpackage

FILE: design/iphs_if.sv
// ----------------------------------------------------------------------------
// iphs channel interfaces
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
interface iphs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [iphs_pkg::PULSE_W-1:0]  pulse_time_us;

  modport source (output valid, mode, pulse_time_us, input ready);
  modport sink   (input valid, mode, pulse_time_us, output ready);
endinterface

interface iphs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          injector_on;
  logic                          pwm_running;
  logic [iphs_pkg::PERIOD_W-1:0] pwm_period;
  logic [iphs_pkg::PERIOD_W-1:0] pwm_high_count;
  logic [2:0]                    phase;
  logic                          done_res;

  modport source (output valid, injector_on, pwm_running, pwm_period, pwm_high_count,
                  phase, done_res, input ready);
  modport sink   (input valid, injector_on, pwm_running, pwm_period, pwm_high_count,
                  phase, done_res, output ready);
endinterface

interface iphs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [iphs_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [iphs_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: design/injector_peak_hold_sequencer_unit.sv
// ----------------------------------------------------------------------------
// injector_peak_hold_sequencer_unit
// peak-and-hold injector drive sequencer with tick counter and pwm settings
// ----------------------------------------------------------------------------
// Every input transaction (a tick or a service call) gives one result
// transaction. The unit takes a new transaction every clock cycle while the
// output side is not stalled: it goes through an input register, then the
// sequencer logic that updates the phase state and the result register. The
// pwm high count is duty * period / 100, saturating at 65535; the three
// products are kept in registers that follow the setting registers, so a
// setting takes effect for transactions accepted from the next cycle on. The
// divide by TICK_US of the pulse time is done at the input register. The
// setting port is always ready once out of reset; unknown register indexes
// are ignored.
`include "assert_macros.svh"

module injector_peak_hold_sequencer_unit #(
  parameter int COUNT_WIDTH = 16,
  parameter int TICK_US     = 10
) (
  input  logic clk,
  input  logic rst_n,
  iphs_in_if.sink    in_ch,
  iphs_out_if.source out_ch,
  iphs_cfg_if.sink   cfg_ch
);

  localparam int PULSE_W  = iphs_pkg::PULSE_W;
  localparam int PERIOD_W = iphs_pkg::PERIOD_W;
  localparam int TICKS_W  = iphs_pkg::TICKS_W;
  localparam int DUTY_W   = iphs_pkg::DUTY_W;
  localparam int ELAP_W   = iphs_pkg::ELAP_W;
  localparam int PROD_W   = iphs_pkg::PROD_W;

  // reciprocal of TICK_US, exact for 16-bit pulse times
  localparam int RECIP_SHIFT = PULSE_W + 7;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] TICK_RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + TICK_US - 1) / TICK_US);
  localparam int QPROD_W = PULSE_W + RECIP_W;

  localparam int CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;
  localparam int SUM_W = ((COUNT_WIDTH > ELAP_W) ? COUNT_WIDTH : ELAP_W) + 1;

  localparam int Y_W    = PROD_W - 2;
  localparam int DPROD_W = Y_W + iphs_pkg::DIV25_MUL_W;
  localparam int HC_W   = DPROD_W - iphs_pkg::DIV25_SHIFT;

  // setting registers
  logic [TICKS_W-1:0]  peak_ticks_r, second_ticks_r, off_ticks_r;
  logic [PERIOD_W-1:0] fast_period_r, hold_period_r;
  logic [DUTY_W-1:0]   peak_duty_r, second_duty_r, hold_duty_r;
  logic [PROD_W-1:0]   prod_peak_r, prod_second_r, prod_hold_r;

  // handshake
  logic run_r;
  logic s1_valid_r, out_valid_r;
  logic s1_mode_r;
  logic [PULSE_W-1:0] s1_qticks_r;
  logic in_fire, out_adv, s1_fire;
  logic [QPROD_W-1:0] qprod;

  // sequencer state
  iphs_pkg::phase_t   phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [ELAP_W-1:0]  elapsed_r, elapsed_nxt;
  logic burst_r, burst_nxt;
  logic wait_done_r, wait_done_nxt;
  logic inj_level_r, inj_level_nxt;
  logic pwm_on_r, pwm_on_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] width_r, width_nxt;
  logic out_done_r, out_done_nxt;

  // pwm high count
  logic [PROD_W-1:0]  prod_sel;
  logic [DPROD_W-1:0] dprod;
  logic [HC_W-1:0]    hc_full;
  logic [PERIOD_W-1:0] hc_sat;

  logic [CMP_W-1:0] tick_cmp;
  logic [SUM_W-1:0] hold_sum;

  assign out_adv = !out_valid_r || out_ch.ready;
  assign s1_fire = s1_valid_r && out_adv;
  assign in_ch.ready = run_r && (!s1_valid_r || out_adv);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = run_r;

  assign qprod = QPROD_W'(in_ch.pulse_time_us) * QPROD_W'(TICK_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r          <= 1'b0;
      peak_ticks_r   <= iphs_pkg::RST_PEAK_TICKS;
      second_ticks_r <= iphs_pkg::RST_SECOND_TICKS;
      off_ticks_r    <= iphs_pkg::RST_OFF_TICKS;
      fast_period_r  <= iphs_pkg::RST_FAST_PERIOD;
      hold_period_r  <= iphs_pkg::RST_HOLD_PERIOD;
      peak_duty_r    <= iphs_pkg::RST_PEAK_DUTY;
      second_duty_r  <= iphs_pkg::RST_SECOND_DUTY;
      hold_duty_r    <= iphs_pkg::RST_HOLD_DUTY;
    end else begin
      run_r <= 1'b1;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          iphs_pkg::REG_PEAK_TICKS:   peak_ticks_r   <= cfg_ch.wdata[TICKS_W-1:0];
          iphs_pkg::REG_SECOND_TICKS: second_ticks_r <= cfg_ch.wdata[TICKS_W-1:0];
          iphs_pkg::REG_OFF_TICKS:    off_ticks_r    <= cfg_ch.wdata[TICKS_W-1:0];
          iphs_pkg::REG_FAST_PERIOD:  fast_period_r  <= cfg_ch.wdata[PERIOD_W-1:0];
          iphs_pkg::REG_HOLD_PERIOD:  hold_period_r  <= cfg_ch.wdata[PERIOD_W-1:0];
          iphs_pkg::REG_PEAK_DUTY:    peak_duty_r    <= cfg_ch.wdata[DUTY_W-1:0];
          iphs_pkg::REG_SECOND_DUTY:  second_duty_r  <= cfg_ch.wdata[DUTY_W-1:0];
          iphs_pkg::REG_HOLD_DUTY:    hold_duty_r    <= cfg_ch.wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // products are registered from the settings and follow them in the cycle after
  always_ff @(posedge clk) begin
    prod_peak_r   <= PROD_W'(peak_duty_r) * PROD_W'(fast_period_r);
    prod_second_r <= PROD_W'(second_duty_r) * PROD_W'(fast_period_r);
    prod_hold_r   <= PROD_W'(hold_duty_r) * PROD_W'(hold_period_r);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r   <= in_ch.mode;
      s1_qticks_r <= qprod[RECIP_SHIFT +: PULSE_W];
    end
  end

  // duty * period / 100 for the product the current phase needs
  always_comb begin
    case (phase_r)
      iphs_pkg::PH_PEAK:   prod_sel = prod_peak_r;
      iphs_pkg::PH_SECOND: prod_sel = prod_second_r;
      default:             prod_sel = prod_hold_r;
    endcase
    dprod   = DPROD_W'(prod_sel[PROD_W-1:2]) * DPROD_W'(iphs_pkg::DIV25_MUL);
    hc_full = dprod[DPROD_W-1:iphs_pkg::DIV25_SHIFT];
    hc_sat  = (hc_full > HC_W'({PERIOD_W{1'b1}})) ? {PERIOD_W{1'b1}}
                                                  : hc_full[PERIOD_W-1:0];
  end

  assign tick_cmp = CMP_W'(tick_r);
  // signed hold compare rewritten as tick + elapsed > pulse / TICK_US
  assign hold_sum = SUM_W'(tick_r) + SUM_W'(elapsed_r);

  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    elapsed_nxt   = elapsed_r;
    burst_nxt     = burst_r;
    wait_done_nxt = wait_done_r;
    inj_level_nxt = inj_level_r;
    pwm_on_nxt    = pwm_on_r;
    period_nxt    = period_r;
    width_nxt     = width_r;
    out_done_nxt  = 1'b0;

    if (!s1_mode_r) begin
      if (tick_r != {COUNT_WIDTH{1'b1}}) begin
        tick_nxt = tick_r + 1'b1;
      end
    end else if (wait_done_r) begin
      wait_done_nxt = 1'b0;
      out_done_nxt  = 1'b1;
    end else begin
      case (phase_r)
        iphs_pkg::PH_IDLE: begin
          tick_nxt    = '0;
          elapsed_nxt = '0;
          burst_nxt   = 1'b1;
          phase_nxt   = iphs_pkg::PH_PEAK;
        end
        iphs_pkg::PH_PEAK: begin
          period_nxt = fast_period_r;
          width_nxt  = hc_sat;
          pwm_on_nxt = 1'b1;
          if (tick_cmp > CMP_W'(peak_ticks_r)) begin
            phase_nxt   = iphs_pkg::PH_SECOND;
            tick_nxt    = '0;
            elapsed_nxt = elapsed_r + ELAP_W'(peak_ticks_r);
          end
        end
        iphs_pkg::PH_SECOND: begin
          width_nxt = hc_sat;
          if (tick_cmp > CMP_W'(second_ticks_r)) begin
            phase_nxt   = iphs_pkg::PH_HOLD;
            tick_nxt    = '0;
            elapsed_nxt = elapsed_r + ELAP_W'(second_ticks_r);
          end
        end
        iphs_pkg::PH_HOLD: begin
          period_nxt = hold_period_r;
          width_nxt  = hc_sat;
          if (hold_sum > SUM_W'(s1_qticks_r)) begin
            phase_nxt   = iphs_pkg::PH_OFF;
            tick_nxt    = '0;
            period_nxt  = fast_period_r;
            elapsed_nxt = ELAP_W'(s1_qticks_r);
          end
        end
        iphs_pkg::PH_OFF: begin
          pwm_on_nxt = 1'b0;
          if (tick_cmp > CMP_W'(off_ticks_r)) begin
            phase_nxt   = iphs_pkg::PH_IDLE;
            tick_nxt    = '0;
            elapsed_nxt = elapsed_r + ELAP_W'(off_ticks_r);
            burst_nxt   = 1'b0;
          end
        end
        default: begin
          phase_nxt = iphs_pkg::PH_IDLE;
        end
      endcase
      inj_level_nxt = burst_nxt;
      if (!burst_nxt) begin
        wait_done_nxt = 1'b1;
      end
    end
  end

  // sequencer state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= iphs_pkg::PH_IDLE;
      tick_r      <= '0;
      elapsed_r   <= '0;
      burst_r     <= 1'b0;
      wait_done_r <= 1'b0;
      inj_level_r <= 1'b0;
      pwm_on_r    <= 1'b0;
      period_r    <= '0;
      width_r     <= '0;
      out_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        elapsed_r   <= elapsed_nxt;
        burst_r     <= burst_nxt;
        wait_done_r <= wait_done_nxt;
        inj_level_r <= inj_level_nxt;
        pwm_on_r    <= pwm_on_nxt;
        period_r    <= period_nxt;
        width_r     <= width_nxt;
        out_done_r  <= out_done_nxt;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.injector_on    = inj_level_r;
  assign out_ch.pwm_running    = pwm_on_r;
  assign out_ch.pwm_period     = period_r;
  assign out_ch.pwm_high_count = width_r;
  assign out_ch.phase          = phase_r;
  assign out_ch.done_res       = out_done_r;

  `ASSERT_SAME(a_burst_phase, clk, rst_n, 1'b1, burst_r == (phase_r != iphs_pkg::PH_IDLE), "burst flag and phase disagree")
  `ASSERT_SAME(a_pwm_idle, clk, rst_n, pwm_on_r, phase_r != iphs_pkg::PH_IDLE, "pwm running while idle")
  `ASSERT_SAME(a_wait_idle, clk, rst_n, wait_done_r, phase_r == iphs_pkg::PH_IDLE && !inj_level_r, "done pending outside idle")
  `ASSERT_NEXT(a_done_next, clk, rst_n, s1_fire && s1_mode_r && wait_done_r, out_done_r && out_valid_r && !wait_done_r, "missing done result")

endmodule
